// File: hw/rtl/rqi_pkg.sv
package rqi_pkg;

  localparam int unsigned FracBits  = 12;
  localparam int unsigned CoordW    = 20;
  localparam int unsigned CfgDataW  = 3 * CoordW;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned DistW     = 32;
  localparam int unsigned ProdW     = 2 * CoordW;
  localparam int unsigned DenW      = ProdW;
  localparam int unsigned NumW      = 44 + FracBits;
  localparam int unsigned QuoW      = DistW;
  localparam int unsigned DivStages = QuoW;
  localparam int unsigned PtProdW   = QuoW + 1 + CoordW;
  localparam int unsigned PSumW     = PtProdW - FracBits + 1;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned XProdW    = DiffW + CoordW;
  localparam int unsigned XCompW    = XProdW + 1;
  localparam int unsigned WProdW    = XCompW + CoordW;
  localparam int unsigned BaryW     = WProdW + 2;
  localparam int unsigned CoefW     = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CORNER = 3'd0,
    CFG_EDGE_U = 3'd1,
    CFG_EDGE_V = 3'd2,
    CFG_NORMAL = 3'd3,
    CFG_SCALED = 3'd4,
    CFG_OFFSET = 3'd5
  } cfg_idx_e;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    coord_t           ray_origin_x;
    coord_t           ray_origin_y;
    coord_t           ray_origin_z;
    coord_t           ray_dir_x;
    coord_t           ray_dir_y;
    coord_t           ray_dir_z;
    logic [DistW-1:0] t_lower;
    logic [DistW-1:0] t_upper;
  } ray_in_t;

  typedef struct packed {
    logic             hit_found;
    logic [DistW-1:0] hit_distance;
    coord_t           hit_point_x;
    coord_t           hit_point_y;
    coord_t           hit_point_z;
    logic             front_face;
    logic [CoefW-1:0] surface_alpha;
    logic [CoefW-1:0] surface_beta;
  } hit_out_t;

  typedef struct packed {
    vec_t             org;
    vec_t             dir;
    logic [DistW-1:0] tlo;
    logic [DistW-1:0] thi;
    logic             front;
    logic             rej;
  } ray_ctx_t;

  function automatic vec_t unpack_vec(logic [CfgDataW-1:0] v);
    vec_t r;
    r.x = v[CoordW-1:0];
    r.y = v[2*CoordW-1:CoordW];
    r.z = v[3*CoordW-1:2*CoordW];
    return r;
  endfunction

endpackage

// File: hw/rtl/ray_quad_intersection.sv
// Ray / parallelogram intersection unit.
// Configuration: write corner, edges, unit normal, scaled normal and plane
// offset through the cfg channel (always ready) while no ray is in flight.
// Rays enter on the ray channel (valid/ready), one transfer per cycle when the
// result side keeps up. Every ray yields exactly one result on the hit
// channel; on a miss all result fields are zero.
// The pipeline has three front stages (products, sums, divider setup),
// a 32-stage restoring divider that settles one quotient bit per stage, and
// six back stages (range test, point products, saturation, cross products,
// weighted products, final compare). Throughput is one ray per cycle while not stalled.
// When the receiver stalls with a result pending, the whole pipeline holds
// and ray_ready_o drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers to zero.
module ray_quad_intersection (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rqi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rqi_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                      ray_valid_i,
  output logic                      ray_ready_o,
  input  rqi_pkg::ray_in_t          ray_i,
  output logic                      hit_valid_o,
  input  logic                      hit_ready_i,
  output rqi_pkg::hit_out_t         hit_o
);
  import rqi_pkg::*;

  localparam logic signed [BaryW-1:0] One3 = BaryW'(1) <<< (3 * FracBits);
  localparam logic signed [PSumW-1:0] SatHi = PSumW'((1 << (CoordW - 1)) - 1);
  localparam logic signed [PSumW-1:0] SatLo = -SatHi - PSumW'(1);

  vec_t corner_q, eu_q, ev_q, nrm_q, wn_q;
  logic signed [DistW-1:0] offset_q;

  logic adv;
  logic out_v_q;
  hit_out_t out_q;

  assign adv         = !out_v_q || hit_ready_i;
  assign ray_ready_o = adv;
  assign cfg_ready_o = 1'b1;
  assign hit_valid_o = out_v_q;
  assign hit_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      eu_q     <= '0;
      ev_q     <= '0;
      nrm_q    <= '0;
      wn_q     <= '0;
      offset_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CORNER: corner_q <= unpack_vec(cfg_data_i);
        CFG_EDGE_U: eu_q     <= unpack_vec(cfg_data_i);
        CFG_EDGE_V: ev_q     <= unpack_vec(cfg_data_i);
        CFG_NORMAL: nrm_q    <= unpack_vec(cfg_data_i);
        CFG_SCALED: wn_q     <= unpack_vec(cfg_data_i);
        CFG_OFFSET: offset_q <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: normal products
  logic v1_q;
  ray_ctx_t c1_q;
  logic signed [ProdW-1:0] nd_q [3];
  logic signed [ProdW-1:0] no_q [3];

  // stage 2: numerator and denominator
  logic v2_q;
  ray_ctx_t c2_q;
  logic [DenW-1:0] den2_q;
  logic [NumW-1:0] num2_q;
  logic signed [ProdW+1:0] den_s;
  logic signed [46:0] num_s, num_a;
  logic [DenW-1:0] den_a;
  logic front_d;

  always_comb begin
    den_s = (ProdW+2)'(nd_q[0]) + (ProdW+2)'(nd_q[1]) + (ProdW+2)'(nd_q[2]);
    num_s = (47'(offset_q) <<< FracBits) - 47'(no_q[0]) - 47'(no_q[1]) - 47'(no_q[2]);
    front_d = den_s < 0;
    num_a = front_d ? -num_s : num_s;
    den_a = front_d ? DenW'(-den_s) : DenW'(den_s);
  end

  // stage 3 and divider chain
  logic v_dv_q [DivStages+1];
  ray_ctx_t c_dv_q [DivStages+1];
  logic [DenW-1:0] den_dv_q [DivStages+1];
  logic [DenW-1:0] r_dv_q [DivStages+1];
  logic [QuoW-1:0] q_dv_q [DivStages+1];
  logic [QuoW-1:0] lo_dv_q [DivStages+1];
  logic [NumW-QuoW-1:0] num_hi;
  assign num_hi = num2_q[NumW-1:QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v_dv_q[0] <= 1'b0;
    end else if (adv) begin
      v1_q <= ray_valid_i;
      v2_q <= v1_q;
      v_dv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= '{org: '{ray_i.ray_origin_x, ray_i.ray_origin_y, ray_i.ray_origin_z},
                dir: '{ray_i.ray_dir_x, ray_i.ray_dir_y, ray_i.ray_dir_z},
                tlo: ray_i.t_lower, thi: ray_i.t_upper,
                front: 1'b0, rej: 1'b0};
      nd_q[0] <= ProdW'(nrm_q.x * ray_i.ray_dir_x);
      nd_q[1] <= ProdW'(nrm_q.y * ray_i.ray_dir_y);
      nd_q[2] <= ProdW'(nrm_q.z * ray_i.ray_dir_z);
      no_q[0] <= ProdW'(nrm_q.x * ray_i.ray_origin_x);
      no_q[1] <= ProdW'(nrm_q.y * ray_i.ray_origin_y);
      no_q[2] <= ProdW'(nrm_q.z * ray_i.ray_origin_z);

      c2_q   <= '{org: c1_q.org, dir: c1_q.dir, tlo: c1_q.tlo, thi: c1_q.thi,
                  front: front_d, rej: (den_s == 0) || (num_a < 0)};
      den2_q <= den_a;
      num2_q <= NumW'(num_a) << FracBits;

      c_dv_q[0]   <= '{org: c2_q.org, dir: c2_q.dir, tlo: c2_q.tlo, thi: c2_q.thi,
                       front: c2_q.front,
                       rej: c2_q.rej || (DenW'(num_hi) >= den2_q)};
      den_dv_q[0] <= den2_q;
      r_dv_q[0]   <= DenW'(num_hi);
      q_dv_q[0]   <= '0;
      lo_dv_q[0]  <= num2_q[QuoW-1:0];
    end
  end

  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    logic [DenW:0] trial;
    logic          ge;
    assign trial = {r_dv_q[k-1], lo_dv_q[k-1][QuoW-1]};
    assign ge    = trial >= {1'b0, den_dv_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_dv_q[k] <= 1'b0;
      end else if (adv) begin
        v_dv_q[k] <= v_dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_dv_q[k]   <= c_dv_q[k-1];
        den_dv_q[k] <= den_dv_q[k-1];
        r_dv_q[k]   <= ge ? DenW'(trial - {1'b0, den_dv_q[k-1]}) : DenW'(trial);
        q_dv_q[k]   <= {q_dv_q[k-1][QuoW-2:0], ge};
        lo_dv_q[k]  <= lo_dv_q[k-1] << 1;
      end
    end
  end

  // stage 4: range test
  logic v4_q;
  ray_ctx_t c4_q;
  logic [QuoW-1:0] quo4_q;
  logic [QuoW-1:0] quo_f;
  logic out_rng;
  ray_ctx_t cf;
  assign quo_f = q_dv_q[DivStages];
  assign cf    = c_dv_q[DivStages];
  assign out_rng = (quo_f < cf.tlo) || (quo_f > cf.thi) ||
                   ((quo_f == cf.thi) && (r_dv_q[DivStages] != '0));

  // stage 5: point products
  logic v5_q;
  ray_ctx_t c5_q;
  logic [QuoW-1:0] quo5_q;
  logic signed [PtProdW-1:0] pp_q [3];
  logic signed [QuoW:0] quo_s;
  assign quo_s = {1'b0, quo4_q};

  // stage 6: saturated point and offset from corner
  logic v6_q;
  ray_ctx_t c6_q;
  logic [QuoW-1:0] quo6_q;
  vec_t pt6_q;
  logic signed [DiffW-1:0] rel_q [3];
  coord_t pt_d [3];
  logic signed [PSumW-1:0] psum [3];
  coord_t org5 [3];
  coord_t crn [3];
  assign org5 = '{c5_q.org.x, c5_q.org.y, c5_q.org.z};
  assign crn  = '{corner_q.x, corner_q.y, corner_q.z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = PSumW'(org5[i]) + PSumW'(pp_q[i] >>> FracBits);
      if (psum[i] > SatHi) pt_d[i] = CoordW'(SatHi);
      else if (psum[i] < SatLo) pt_d[i] = CoordW'(SatLo);
      else pt_d[i] = CoordW'(psum[i]);
    end
  end

  // stage 7: cross products
  logic v7_q;
  ray_ctx_t c7_q;
  logic [QuoW-1:0] quo7_q;
  vec_t pt7_q;
  logic signed [XProdW-1:0] xa_q [6];
  logic signed [XProdW-1:0] xb_q [6];

  // stage 8: weighted cross components
  logic v8_q;
  ray_ctx_t c8_q;
  logic [QuoW-1:0] quo8_q;
  vec_t pt8_q;
  logic signed [WProdW-1:0] wa_q [3];
  logic signed [WProdW-1:0] wb_q [3];
  logic signed [XCompW-1:0] ca [3];
  logic signed [XCompW-1:0] cb [3];
  coord_t wv [3];
  assign wv = '{wn_q.x, wn_q.y, wn_q.z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[i] = XCompW'(xa_q[2*i]) - XCompW'(xa_q[2*i+1]);
      cb[i] = XCompW'(xb_q[2*i]) - XCompW'(xb_q[2*i+1]);
    end
  end

  // stage 9: final compare
  logic signed [BaryW-1:0] alpha, beta;
  logic miss;
  assign alpha = BaryW'(wa_q[0]) + BaryW'(wa_q[1]) + BaryW'(wa_q[2]);
  assign beta  = BaryW'(wb_q[0]) + BaryW'(wb_q[1]) + BaryW'(wb_q[2]);
  assign miss  = c8_q.rej || (alpha < 0) || (alpha > One3) || (beta < 0) || (beta > One3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      v8_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v4_q    <= v_dv_q[DivStages];
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      v8_q    <= v7_q;
      out_v_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c4_q   <= '{org: cf.org, dir: cf.dir, tlo: cf.tlo, thi: cf.thi,
                  front: cf.front, rej: cf.rej || out_rng};
      quo4_q <= quo_f;

      c5_q   <= c4_q;
      quo5_q <= quo4_q;
      pp_q[0] <= PtProdW'(quo_s * c4_q.dir.x);
      pp_q[1] <= PtProdW'(quo_s * c4_q.dir.y);
      pp_q[2] <= PtProdW'(quo_s * c4_q.dir.z);

      c6_q   <= c5_q;
      quo6_q <= quo5_q;
      pt6_q  <= '{pt_d[0], pt_d[1], pt_d[2]};
      for (int i = 0; i < 3; i++) begin
        rel_q[i] <= DiffW'(pt_d[i]) - DiffW'(crn[i]);
      end

      c7_q   <= c6_q;
      quo7_q <= quo6_q;
      pt7_q  <= pt6_q;
      // (P-C) x V
      xa_q[0] <= XProdW'(rel_q[1] * ev_q.z);
      xa_q[1] <= XProdW'(rel_q[2] * ev_q.y);
      xa_q[2] <= XProdW'(rel_q[2] * ev_q.x);
      xa_q[3] <= XProdW'(rel_q[0] * ev_q.z);
      xa_q[4] <= XProdW'(rel_q[0] * ev_q.y);
      xa_q[5] <= XProdW'(rel_q[1] * ev_q.x);
      // U x (P-C)
      xb_q[0] <= XProdW'(eu_q.y * rel_q[2]);
      xb_q[1] <= XProdW'(eu_q.z * rel_q[1]);
      xb_q[2] <= XProdW'(eu_q.z * rel_q[0]);
      xb_q[3] <= XProdW'(eu_q.x * rel_q[2]);
      xb_q[4] <= XProdW'(eu_q.x * rel_q[1]);
      xb_q[5] <= XProdW'(eu_q.y * rel_q[0]);

      c8_q   <= c7_q;
      quo8_q <= quo7_q;
      pt8_q  <= pt7_q;
      for (int i = 0; i < 3; i++) begin
        wa_q[i] <= WProdW'(wv[i] * ca[i]);
        wb_q[i] <= WProdW'(wv[i] * cb[i]);
      end

      if (miss) begin
        out_q <= '0;
      end else begin
        out_q <= '{hit_found: 1'b1,
                   hit_distance: quo8_q,
                   hit_point_x: pt8_q.x,
                   hit_point_y: pt8_q.y,
                   hit_point_z: pt8_q.z,
                   front_face: c8_q.front,
                   surface_alpha: alpha[3*FracBits:2*FracBits],
                   surface_beta: beta[3*FracBits:2*FracBits]};
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_den_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && den2_q == '0) |-> c2_q.rej) else $error("zero denominator not rejected");
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.hit_found) |->
      (out_q.surface_alpha <= CoefW'(1 << FracBits) &&
       out_q.surface_beta <= CoefW'(1 << FracBits)))
    else $error("coefficient out of range on hit");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.hit_found) |-> (out_q == '0)) else $error("miss result not zero");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(v4_q) && $stable(v_dv_q[0]) && $stable(v8_q)))
    else $error("pipeline moved during stall");
`endif

endmodule
